FILE: hdl/uartrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer package
// Shared constants, request codes, status codes and ring command type.
// ----------------------------------------------------------------------------
package uartrb_pkg;

   localparam int RX_DEPTH_DEF = 4;
   localparam int TX_DEPTH_DEF = 32;

   localparam logic [7:0] LINE_FEED       = 8'h0A;
   localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;

   typedef enum logic [1:0] {
      OP_PUT      = 2'd0,
      OP_GET      = 2'd1,
      OP_RX_BYTE  = 2'd2,
      OP_TX_READY = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_TX_FULL    = 2'd1,
      STATUS_RX_EMPTY   = 2'd2,
      STATUS_RX_OVERRUN = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0] push_count;
      logic       pop;
   } ring_cmd_type;

endpackage

FILE: hdl/uartrb_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer request channel
// Valid/ready channel carrying one request: opcode and data byte.
// ----------------------------------------------------------------------------
interface uartrb_req_if;

   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink   (input valid, input opcode, input data_byte, output ready);

endinterface

FILE: hdl/uartrb_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer response channel
// Valid/ready channel carrying the result of one request.
// ----------------------------------------------------------------------------
interface uartrb_rsp_if #(
   parameter int RX_COUNT_W = $clog2(uartrb_pkg::RX_DEPTH_DEF + 1),
   parameter int TX_COUNT_W = $clog2(uartrb_pkg::TX_DEPTH_DEF + 1)
);

   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [7:0]            read_byte;
   logic                  tx_valid;
   logic [7:0]            tx_byte;
   logic [RX_COUNT_W-1:0] rx_count;
   logic [TX_COUNT_W-1:0] tx_count;

   modport source (
      output valid, output status, output read_byte, output tx_valid,
      output tx_byte, output rx_count, output tx_count, input ready
   );
   modport sink (
      input valid, input status, input read_byte, input tx_valid,
      input tx_byte, input rx_count, input tx_count, output ready
   );

endinterface

FILE: hdl/uartrb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module uartrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = uartrb_pkg::TX_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/uartrb_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer pointer control
// Read and write pointers counting modulo twice the depth, slots and fill.
// ----------------------------------------------------------------------------
module uartrb_ring #(
   parameter int DEPTH = uartrb_pkg::TX_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  uartrb_pkg::ring_cmd_type   cmd,
   output logic [$clog2(DEPTH)-1:0]   wr_slot,
   output logic [$clog2(DEPTH)-1:0]   wr_slot_plus1,
   output logic [$clog2(DEPTH)-1:0]   rd_slot,
   output logic [$clog2(DEPTH+1)-1:0] fill,
   output logic [$clog2(DEPTH+1)-1:0] fill_next
);

   import uartrb_pkg::*;

   localparam int PW  = $clog2(2 * DEPTH);
   localparam int PW1 = PW + 1;
   localparam int SW  = $clog2(DEPTH);
   localparam int FW  = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(2 * DEPTH - 1);
   localparam logic [PW-1:0] PTR_HALF = PW'(DEPTH);

   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff;
   logic [PW-1:0] rd_ptr_in;
   logic [PW-1:0] wr_ptr_inc;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [SW-1:0] ptr_slot(input logic [PW-1:0] p);
      return (p >= PTR_HALF) ? SW'(p - PTR_HALF) : SW'(p);
   endfunction

   function automatic logic [FW-1:0] ptr_fill(input logic [PW-1:0] w,
                                              input logic [PW-1:0] r);
      logic [PW1-1:0] diff;
      diff = {1'b0, w} - {1'b0, r};
      if (w < r) begin
         diff = diff + PW1'(2 * DEPTH);
      end
      return FW'(diff);
   endfunction

   assign wr_ptr_inc = ptr_inc(wr_ptr_ff);

   always_comb begin
      unique case (cmd.push_count)
         2'd1:    wr_ptr_in = wr_ptr_inc;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr_inc);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = cmd.pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   assign wr_slot       = ptr_slot(wr_ptr_ff);
   assign wr_slot_plus1 = ptr_slot(wr_ptr_inc);
   assign rd_slot       = ptr_slot(rd_ptr_ff);
   assign fill          = ptr_fill(wr_ptr_ff, rd_ptr_ff);
   assign fill_next     = ptr_fill(wr_ptr_in, rd_ptr_in);

endmodule

FILE: hdl/uart_rx_tx_ring_buffers_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART receive and transmit ring buffers
// Host put/get and line receive/transmit-ready requests on two byte rings.
// ----------------------------------------------------------------------------
// Requests arrive on req_if (opcode, data_byte) and each produces exactly one
// response on rsp_if. The csr write port sets crlf_enable, which makes a put
// of a line feed queue a carriage return first.
// Both rings live in RAMs with a registered read; the pointers sit
// in flip-flops, so full and empty decisions are made when a request is taken.
// Puts without a carriage return, line receives, failed gets and idle
// transmit-ready requests respond from the response registers, and the block
// can take one of these every cycle. A successful get or a transmit-ready that
// pops a byte waits for the registered RAM read and then responds. A put that
// inserts a carriage return needs two writes to the single RAM write port and
// holds off requests for the second write. A new request is taken while the
// previous response is taken in the same cycle; requests wait while it stalls.
// Reset empties both rings, marks the transmitter idle and sets crlf_enable.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_core #(
   parameter int RX_DEPTH = uartrb_pkg::RX_DEPTH_DEF,
   parameter int TX_DEPTH = uartrb_pkg::TX_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   uartrb_req_if.sink         req_if,
   uartrb_rsp_if.source       rsp_if,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);

   import uartrb_pkg::*;

   localparam int RX_SW = $clog2(RX_DEPTH);
   localparam int RX_FW = $clog2(RX_DEPTH + 1);
   localparam int TX_SW = $clog2(TX_DEPTH);
   localparam int TX_FW = $clog2(TX_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE2,
      ST_READ
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic              crlf_ff;
   logic              crlf_in;
   logic              tx_idle_ff;
   logic              tx_idle_in;
   logic              byte_from_rx_ff;
   logic              byte_from_rx_in;
   logic [TX_SW-1:0]  second_slot_ff;
   logic [TX_SW-1:0]  second_slot_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   status_type        status_ff;
   status_type        status_in;
   logic [7:0]        read_byte_ff;
   logic [7:0]        read_byte_in;
   logic              tx_valid_ff;
   logic              tx_valid_in;
   logic [7:0]        tx_byte_ff;
   logic [7:0]        tx_byte_in;
   logic [RX_FW-1:0]  rx_count_ff;
   logic [RX_FW-1:0]  rx_count_in;
   logic [TX_FW-1:0]  tx_count_ff;
   logic [TX_FW-1:0]  tx_count_in;

   logic              req_accept;
   opcode_type        op;
   logic [7:0]        data;
   logic              add_cr;
   logic [7:0]        first_byte;

   ring_cmd_type      rx_cmd;
   ring_cmd_type      tx_cmd;
   logic [RX_SW-1:0]  rx_wr_slot;
   logic [RX_SW-1:0]  rx_rd_slot;
   logic [RX_FW-1:0]  rx_fill;
   logic [RX_FW-1:0]  rx_fill_next;
   logic [TX_SW-1:0]  tx_wr_slot;
   logic [TX_SW-1:0]  tx_wr_slot_plus1;
   logic [TX_SW-1:0]  tx_rd_slot;
   logic [TX_FW-1:0]  tx_fill;
   logic [TX_FW-1:0]  tx_fill_next;
   logic [TX_FW-1:0]  tx_free;

   logic              rx_empty;
   logic              rx_full;
   logic              tx_empty;
   logic              tx_full;

   logic              rx_ram_we;
   logic              rx_ram_re;
   logic [7:0]        rx_ram_rdata;
   logic              tx_ram_we;
   logic              tx_ram_re;
   logic [TX_SW-1:0]  tx_ram_waddr;
   logic [7:0]        tx_ram_wdata;
   logic [7:0]        tx_ram_rdata;

   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;
   assign op           = opcode_type'(req_if.opcode);
   assign data         = req_if.data_byte;

   assign add_cr     = crlf_ff && (data == LINE_FEED);
   assign first_byte = add_cr ? CARRIAGE_RETURN : data;

   assign tx_free  = TX_FW'(TX_DEPTH) - tx_fill;
   assign tx_full  = add_cr ? (tx_free < TX_FW'(2)) : (tx_free == '0);
   assign tx_empty = (tx_fill == '0);
   assign rx_empty = (rx_fill == '0);
   assign rx_full  = (rx_fill == RX_FW'(RX_DEPTH));

   always_comb begin
      rx_cmd = '0;
      tx_cmd = '0;
      if (req_accept) begin
         unique case (op)
            OP_PUT: begin
               if (!tx_full) begin
                  tx_cmd.push_count = add_cr ? 2'd2 : 2'd1;
                  tx_cmd.pop        = tx_idle_ff;
               end
            end
            OP_GET: begin
               rx_cmd.pop = !rx_empty;
            end
            OP_RX_BYTE: begin
               rx_cmd.push_count = rx_full ? 2'd0 : 2'd1;
            end
            OP_TX_READY: begin
               tx_cmd.pop = !tx_empty;
            end
            default: begin
               rx_cmd = '0;
            end
         endcase
      end
   end

   uartrb_ring #(
      .DEPTH (RX_DEPTH)
   ) u_rx_ring (
      .clock         (clock),
      .reset         (reset),
      .cmd           (rx_cmd),
      .wr_slot       (rx_wr_slot),
      .wr_slot_plus1 (),
      .rd_slot       (rx_rd_slot),
      .fill          (rx_fill),
      .fill_next     (rx_fill_next)
   );

   uartrb_ring #(
      .DEPTH (TX_DEPTH)
   ) u_tx_ring (
      .clock         (clock),
      .reset         (reset),
      .cmd           (tx_cmd),
      .wr_slot       (tx_wr_slot),
      .wr_slot_plus1 (tx_wr_slot_plus1),
      .rd_slot       (tx_rd_slot),
      .fill          (tx_fill),
      .fill_next     (tx_fill_next)
   );

   assign rx_ram_we = (rx_cmd.push_count != 2'd0);
   assign rx_ram_re = rx_cmd.pop;

   uartrb_ram #(
      .WIDTH (8),
      .DEPTH (RX_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_ram_we),
      .wr_addr (rx_wr_slot),
      .wr_data (data),
      .rd_en   (rx_ram_re),
      .rd_addr (rx_rd_slot),
      .rd_data (rx_ram_rdata)
   );

   // The second write of a carriage return put always stores the line feed.
   assign tx_ram_we    = (tx_cmd.push_count != 2'd0) || (state_ff == ST_WRITE2);
   assign tx_ram_waddr = (state_ff == ST_WRITE2) ? second_slot_ff : tx_wr_slot;
   assign tx_ram_wdata = (state_ff == ST_WRITE2) ? LINE_FEED : first_byte;
   assign tx_ram_re    = req_accept && (op == OP_TX_READY) && !tx_empty;

   uartrb_ram #(
      .WIDTH (8),
      .DEPTH (TX_DEPTH)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_ram_we),
      .wr_addr (tx_ram_waddr),
      .wr_data (tx_ram_wdata),
      .rd_en   (tx_ram_re),
      .rd_addr (tx_rd_slot),
      .rd_data (tx_ram_rdata)
   );

   always_comb begin
      state_in        = state_ff;
      crlf_in         = csr_wr_en ? csr_wr_data : crlf_ff;
      tx_idle_in      = tx_idle_ff;
      byte_from_rx_in = byte_from_rx_ff;
      second_slot_in  = second_slot_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      status_in       = status_ff;
      read_byte_in    = read_byte_ff;
      tx_valid_in     = tx_valid_ff;
      tx_byte_in      = tx_byte_ff;
      rx_count_in     = rx_count_ff;
      tx_count_in     = tx_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            second_slot_in = tx_wr_slot_plus1;
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_OK;
               read_byte_in = '0;
               tx_valid_in  = 1'b0;
               tx_byte_in   = '0;
               rx_count_in  = rx_fill_next;
               tx_count_in  = tx_fill_next;
               unique case (op)
                  OP_PUT: begin
                     if (tx_full) begin
                        status_in = STATUS_TX_FULL;
                     end else begin
                        if (add_cr) begin
                           state_in = ST_WRITE2;
                        end
                        // An idle transmitter always has an empty ring, so the
                        // byte to send is the first one queued by this put.
                        if (tx_idle_ff) begin
                           tx_valid_in = 1'b1;
                           tx_byte_in  = first_byte;
                           tx_idle_in  = 1'b0;
                        end
                     end
                  end
                  OP_GET: begin
                     if (rx_empty) begin
                        status_in = STATUS_RX_EMPTY;
                     end else begin
                        state_in        = ST_READ;
                        rsp_valid_in    = 1'b0;
                        byte_from_rx_in = 1'b1;
                     end
                  end
                  OP_RX_BYTE: begin
                     if (rx_full) begin
                        status_in = STATUS_RX_OVERRUN;
                     end
                  end
                  OP_TX_READY: begin
                     if (tx_empty) begin
                        tx_idle_in = 1'b1;
                     end else begin
                        tx_valid_in     = 1'b1;
                        tx_idle_in      = 1'b0;
                        state_in        = ST_READ;
                        rsp_valid_in    = 1'b0;
                        byte_from_rx_in = 1'b0;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_WRITE2: begin
            state_in = ST_IDLE;
         end
         ST_READ: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (byte_from_rx_ff) begin
               read_byte_in = rx_ram_rdata;
            end else begin
               tx_byte_in = tx_ram_rdata;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         crlf_ff      <= 1'b1;
         tx_idle_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crlf_ff      <= crlf_in;
         tx_idle_ff   <= tx_idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_from_rx_ff <= byte_from_rx_in;
      second_slot_ff  <= second_slot_in;
      status_ff       <= status_in;
      read_byte_ff    <= read_byte_in;
      tx_valid_ff     <= tx_valid_in;
      tx_byte_ff      <= tx_byte_in;
      rx_count_ff     <= rx_count_in;
      tx_count_ff     <= tx_count_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = status_ff;
   assign rsp_if.read_byte = read_byte_ff;
   assign rsp_if.tx_valid  = tx_valid_ff;
   assign rsp_if.tx_byte   = tx_byte_ff;
   assign rsp_if.rx_count  = rx_count_ff;
   assign rsp_if.tx_count  = tx_count_ff;

endmodule
